FILE: rtl/rtdp_pkg.sv
// Package for the rotate-then-drive controller: constants, phase codes, arc table.
// Used by all modules under rtl; depends on nothing.
package rtdp_pkg;
  localparam int CordicSteps = 16;
  localparam logic signed [40:0] FullTurn = 41'sd411566;
  localparam logic signed [43:0] QuarterPi = 44'sd1686629713;
  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhRot = 2'd1;
  localparam logic [1:0] PhDrive = 2'd2;
  localparam logic [1:0] RegMax = 2'd0;
  localparam logic [1:0] RegAng = 2'd1;
  localparam logic [1:0] RegPos = 2'd2;

  typedef struct packed {
    logic start_atan;
    logic start_sqrt;
    logic start_mul;
  } cmd_t;

  typedef struct packed {
    logic atan_done;
    logic sqrt_done;
    logic mul_done;
  } sts_t;

  function automatic logic [43:0] arc(input logic [4:0] i);
    logic [43:0] r;
    case (i)
      5'd0: r = 44'd843314856;  5'd1: r = 44'd497837829;
      5'd2: r = 44'd263043836;  5'd3: r = 44'd133525158;
      5'd4: r = 44'd67021686;   5'd5: r = 44'd33543515;
      5'd6: r = 44'd16775850;   5'd7: r = 44'd8388437;
      5'd8: r = 44'd4194282;    5'd9: r = 44'd2097149;
      5'd10: r = 44'd1048575;   5'd11: r = 44'd524287;
      5'd12: r = 44'd262143;    5'd13: r = 44'd131071;
      5'd14: r = 44'd65535;     5'd15: r = 44'd32767;
      5'd16: r = 44'd16383;     5'd17: r = 44'd8191;
      5'd18: r = 44'd4095;      5'd19: r = 44'd2047;
      5'd20: r = 44'd1023;      5'd21: r = 44'd511;
      5'd22: r = 44'd255;       5'd23: r = 44'd127;
      5'd24: r = 44'd63;        5'd25: r = 44'd31;
      5'd26: r = 44'd15;        5'd27: r = 44'd7;
      5'd28: r = 44'd3;         5'd29: r = 44'd1;
      default: r = 44'd0;
    endcase
    return r;
  endfunction
endpackage

FILE: rtl/rtdp_ctrl.sv
// Sequencer for the rotate-then-drive controller.
// Depends on rtdp_pkg; drives rtdp_datapath through cmd_t and reads sts_t.
module rtdp_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  logic action,
  input  logic [1:0] phase,
  input  logic out_ready,
  input  rtdp_pkg::sts_t sts,
  output rtdp_pkg::cmd_t cmd,
  output logic in_ready,
  output logic calc_rot,
  output logic load_out,
  output logic out_valid
);
  import rtdp_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ATAN = 6'b000010,
    S_MULR = 6'b000100,
    S_SQRT = 6'b001000,
    S_MULD = 6'b010000,
    S_OUT  = 6'b100000
  } st_t;

  st_t st, st_next;
  logic ov, ov_next;
  logic is_goal, is_goal_next;
  logic rot_job, rot_job_next;

  assign out_valid = ov;
  assign in_ready = (st == S_IDLE) && !ov;
  assign calc_rot = rot_job;

  always_comb begin
    st_next = st;
    ov_next = ov && !out_ready;
    is_goal_next = is_goal;
    rot_job_next = rot_job;
    cmd = '0;
    load_out = 1'b0;
    case (st)
      S_IDLE: begin
        if (in_fire) begin
          is_goal_next = action;
          rot_job_next = !action && (phase == PhRot);
          if (action || phase == PhRot) begin
            st_next = S_ATAN;
            cmd.start_atan = 1'b1;
          end else if (phase == PhDrive) begin
            st_next = S_SQRT;
            cmd.start_sqrt = 1'b1;
          end
        end
      end
      S_ATAN: begin
        if (sts.atan_done) begin
          if (is_goal) st_next = S_IDLE;
          else begin
            st_next = S_MULR;
            cmd.start_mul = 1'b1;
          end
        end
      end
      S_SQRT: begin
        if (sts.sqrt_done) begin
          st_next = S_MULD;
          cmd.start_mul = 1'b1;
        end
      end
      S_MULR, S_MULD: begin
        if (sts.mul_done) st_next = S_OUT;
      end
      S_OUT: begin
        load_out = 1'b1;
        ov_next = 1'b1;
        st_next = S_IDLE;
      end
      default: st_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      ov <= 1'b0;
      is_goal <= 1'b0;
      rot_job <= 1'b0;
    end else begin
      st <= st_next;
      ov <= ov_next;
      is_goal <= is_goal_next;
      rot_job <= rot_job_next;
    end
  end
endmodule

FILE: rtl/rtdp_datapath.sv
// Datapath: state registers, shared CORDIC, bit-serial root, serial multiplier.
// Depends on rtdp_pkg; sequenced by rtdp_ctrl.
module rtdp_datapath (
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  logic action,
  input  logic signed [31:0] goal_x,
  input  logic signed [31:0] goal_y,
  input  logic signed [31:0] odom_x,
  input  logic signed [31:0] odom_y,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  input  logic signed [15:0] quat_w,
  input  logic cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [19:0] cfg_data,
  input  rtdp_pkg::cmd_t cmd,
  input  logic calc_rot,
  input  logic load_out,
  output rtdp_pkg::sts_t sts,
  output logic [1:0] phase,
  output logic signed [19:0] angular_rate,
  output logic [18:0] linear_rate,
  output logic goal_reached,
  output logic [1:0] phase_now
);
  import rtdp_pkg::*;

  logic [18:0] speed_lim;
  logic [16:0] ang_tol;
  logic [19:0] pos_tol;
  logic signed [31:0] last_x, last_y, tgt_x, tgt_y;
  logic signed [40:0] tgt_head;
  logic goal_job;

  // CORDIC
  logic signed [43:0] cx, cy, cz;
  logic [5:0] ci;
  logic cbusy;
  logic signed [43:0] pre_x, pre_y, pre_z;
  logic signed [43:0] vx, vy;
  logic signed [40:0] angle, wrapped;

  always_comb begin
    pre_x = vx; pre_y = vy; pre_z = '0;
    if (vx < 0) begin
      if (vy >= 0) begin
        pre_x = vy; pre_y = -vx; pre_z = QuarterPi;
      end else begin
        pre_x = -vy; pre_y = vx; pre_z = -QuarterPi;
      end
    end
  end

  logic signed [33:0] num, den;
  always_comb begin
    num = 34'(2 * (32'(quat_w) * 32'(quat_z) + 32'(quat_x) * 32'(quat_y)));
    den = 34'sd268435456 - 34'(2 * (32'(quat_y) * 32'(quat_y) + 32'(quat_z) * 32'(quat_z)));
    if (action) begin
      vx = 44'(34'(goal_x) - 34'(last_x));
      vy = 44'(34'(goal_y) - 34'(last_y));
    end else begin
      vx = 44'(den);
      vy = 44'(num);
    end
  end

  logic signed [43:0] zr;
  assign zr = (cz + 44'sd8192) >>> 14;
  assign angle = 41'(zr);
  assign wrapped = (angle < 0) ? angle + FullTurn : angle;

  // Root: 64-bit radicand, two bits a cycle.
  logic [63:0] rv, rres, rbit;
  logic rbusy, rsat;
  logic signed [32:0] dxs, dys;
  assign dxs = 33'(tgt_x) - 33'(odom_x);
  assign dys = 33'(tgt_y) - 33'(odom_y);
  logic [32:0] adx, ady;
  assign adx = dxs[32] ? 33'(-dxs) : 33'(dxs);
  assign ady = dys[32] ? 33'(-dys) : 33'(dys);
  logic [31:0] root_q;

  // Serial multiplier: speed limit x heading error or distance, 2 bits a cycle.
  logic [50:0] mcand, macc;
  logic [31:0] mplier;
  logic [4:0] mcnt;
  logic mbusy;
  logic [40:0] diff;
  logic [40:0] mag;
  assign diff = tgt_head - wrapped;
  assign mag = diff[40] ? 41'(-diff) : diff;
  logic [50:0] prod;
  assign prod = macc >> 16;
  logic [18:0] lim;
  assign lim = (prod < 51'(speed_lim)) ? 19'(prod) : speed_lim;

  logic c_end, r_end, m_end;
  assign c_end = (ci == 6'(CordicSteps)) || (cx == 0 && cy == 0 && cz == -44'sd8192);
  assign r_end = (rbit == 0);
  assign m_end = (mcnt == 5'd16);

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_lim <= 19'd32768; ang_tol <= 17'd655; pos_tol <= 20'd6554;
      phase <= PhIdle; last_x <= '0; last_y <= '0; tgt_x <= '0; tgt_y <= '0;
      tgt_head <= '0; cbusy <= 1'b0; rbusy <= 1'b0; mbusy <= 1'b0;
      sts <= '0; goal_job <= 1'b0; phase_now <= PhIdle; goal_reached <= 1'b0;
      angular_rate <= '0; linear_rate <= '0;
    end else begin
      sts <= '{atan_done: cbusy && !cmd.start_atan && c_end,
               sqrt_done: rbusy && !cmd.start_sqrt && r_end,
               mul_done: mbusy && !cmd.start_mul && m_end};
      if (cfg_we) begin
        case (cfg_idx)
          RegMax: speed_lim <= cfg_data[18:0];
          RegAng: ang_tol <= cfg_data[16:0];
          RegPos: pos_tol <= cfg_data;
          default: ;
        endcase
      end
      if (in_fire) begin
        goal_job <= action;
        if (action) begin
          tgt_x <= goal_x; tgt_y <= goal_y;
          phase <= PhRot;
        end else begin
          last_x <= odom_x; last_y <= odom_y;
        end
      end
      if (cmd.start_atan) begin
        cx <= pre_x; cy <= pre_y; ci <= '0;
        cz <= (vx == 0 && vy == 0) ? -44'sd8192 : pre_z;
        cbusy <= 1'b1;
      end else if (cbusy) begin
        if (c_end) begin
          cbusy <= 1'b0;
          if (goal_job) tgt_head <= wrapped;
        end else begin
          if (cy >= 0) begin
            cx <= cx + (cy >>> ci); cy <= cy - (cx >>> ci); cz <= cz + arc(ci[4:0]);
          end else begin
            cx <= cx - (cy >>> ci); cy <= cy + (cx >>> ci); cz <= cz - arc(ci[4:0]);
          end
          ci <= ci + 6'd1;
        end
      end
      if (cmd.start_sqrt) begin
        rsat <= adx[31] || adx[32] || ady[31] || ady[32];
        rv <= 64'(adx[30:0]) * 64'(adx[30:0]) + 64'(ady[30:0]) * 64'(ady[30:0]);
        rres <= '0; rbit <= 64'h4000_0000_0000_0000; rbusy <= 1'b1;
      end else if (rbusy) begin
        if (r_end) begin
          rbusy <= 1'b0;
          root_q <= rsat ? 32'h8000_0000 : rres[31:0];
        end else begin
          if (rv >= rres + rbit) begin
            rv <= rv - (rres + rbit); rres <= (rres >> 1) + rbit;
          end else rres <= rres >> 1;
          rbit <= rbit >> 2;
        end
      end
      if (cmd.start_mul) begin
        mcand <= 51'(speed_lim); macc <= '0; mcnt <= '0; mbusy <= 1'b1;
        if (sts.sqrt_done) mplier <= root_q;
        else mplier <= (mag[40:32] != 0) ? 32'hFFFF_FFFF : 32'(mag);
      end else if (mbusy) begin
        if (m_end) begin
          mbusy <= 1'b0;
        end else begin
          macc <= macc + (mplier[0] ? mcand : '0) + (mplier[1] ? (mcand << 1) : '0);
          mcand <= mcand << 2; mplier <= mplier >> 2; mcnt <= mcnt + 5'd1;
        end
      end
      if (load_out) begin
        if (calc_rot) begin
          linear_rate <= '0; goal_reached <= 1'b0;
          if (mag < 41'(ang_tol)) begin
            phase <= PhDrive; phase_now <= PhDrive; angular_rate <= '0;
          end else begin
            phase_now <= PhRot;
            angular_rate <= diff[40] ? 20'(-$signed({1'b0, lim})) :
                            (diff == 0 ? 20'sd0 : 20'($signed({1'b0, lim})));
          end
        end else begin
          angular_rate <= '0;
          if (root_q < 32'(pos_tol)) begin
            goal_reached <= 1'b1; phase <= PhIdle; phase_now <= PhIdle;
            linear_rate <= '0;
          end else begin
            goal_reached <= 1'b0; phase_now <= PhDrive; linear_rate <= lim;
          end
        end
      end
    end
  end
endmodule

FILE: rtl/rotate_then_drive_to_point.sv
// Top level of the rotate-then-drive controller.
// Depends on rtdp_pkg, rtdp_ctrl and rtdp_datapath.
//
// Input beats carry either a goal (action high) or an odometry sample. A goal
// runs a CORDIC heading and gives no result. An odometry sample while rotating
// runs the CORDIC for yaw and a serial multiply; while driving it runs the
// bit-serial root and the multiply; while idle it only records position.
// A goal holds off further input while its CORDIC heading runs. A rotate sample
// runs the CORDIC and then the multiply before its result beat; a drive sample
// runs the root and then the multiply (32 root steps, 16 multiply steps).
// Idle odometry beats are taken back to back. One item is in work at a time.
// The result beat waits in an output register; a stalled receiver holds it
// and the next input is accepted the cycle after that beat is taken.
// Reset restores the register defaults and returns the phase to idle.
module rotate_then_drive_to_point (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic action,
  input  logic signed [31:0] goal_x,
  input  logic signed [31:0] goal_y,
  input  logic signed [31:0] odom_x,
  input  logic signed [31:0] odom_y,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  input  logic signed [15:0] quat_w,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [19:0] angular_rate,
  output logic [18:0] linear_rate,
  output logic goal_reached,
  output logic [1:0] phase_now,
  input  logic cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [19:0] cfg_data
);
  import rtdp_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic calc_rot, load_out, in_fire;
  logic [1:0] phase;

  assign in_fire = in_valid && in_ready;

  rtdp_ctrl u_ctrl (
    .clk, .rst, .in_fire, .action, .phase, .out_ready, .sts, .cmd,
    .in_ready, .calc_rot, .load_out, .out_valid
  );

  rtdp_datapath u_dp (
    .clk, .rst, .in_fire, .action, .goal_x, .goal_y, .odom_x, .odom_y,
    .quat_x, .quat_y, .quat_z, .quat_w, .cfg_we, .cfg_idx, .cfg_data,
    .cmd, .calc_rot, .load_out, .sts, .phase, .angular_rate, .linear_rate,
    .goal_reached, .phase_now
  );

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(angular_rate))
    else $error("result beat changed while stalled");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(linear_rate != 0 && angular_rate != 0))
    else $error("both rates nonzero");
endmodule

FILE: dv/rotate_then_drive_to_point_tb.sv
// Testbench for rotate_then_drive_to_point: goal and odometry beats with random gaps,
// results checked against an in-bench fixed-point model of the controller.
// Depends on rtdp_pkg and the RTL under rtl.
`timescale 1ns / 100ps

module rotate_then_drive_to_point_tb;
  import rtdp_pkg::*;

  localparam int HalfTurn = 205783;
  localparam longint QuarterArc = 1686629713;
  localparam int WatchLimit = 2000;

  typedef struct {
    logic action;
    logic signed [31:0] gx, gy, ox, oy;
    logic signed [15:0] qx, qy, qz, qw;
  } beat_t;

  typedef struct {
    logic signed [19:0] ang;
    logic [18:0] lin;
    logic reached;
    logic [1:0] ph;
  } cmd_beat_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic action = 0;
  logic signed [31:0] goal_x = 0, goal_y = 0, odom_x = 0, odom_y = 0;
  logic signed [15:0] quat_x = 0, quat_y = 0, quat_z = 0, quat_w = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [19:0] angular_rate;
  logic [18:0] linear_rate;
  logic goal_reached;
  logic [1:0] phase_now;
  logic cfg_we = 0;
  logic [1:0] cfg_idx = 0;
  logic [19:0] cfg_data = 0;

  beat_t pending[$];
  beat_t staged[$];
  cmd_beat_t expected_cmds[$];
  int errors = 0;
  int watch = 0;
  bit finished = 0;

  longint m_speed, m_angtol, m_postol;
  logic [1:0] m_phase;
  longint m_lx, m_ly, m_tx, m_ty, m_head;

  rotate_then_drive_to_point dut (.*);

  always #5 clk = ~clk;

  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint arc_q30(int i);
    longint tbl[32] = '{843314856, 497837829, 263043836, 133525158, 67021686,
      33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
      131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63,
      31, 15, 7, 3, 1, 0, 0};
    return tbl[i];
  endfunction

  function automatic longint heading(longint y, longint x);
    longint z, t, dx, dy, a;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = QuarterArc;
      end else begin
        t = x; x = -y; y = t; z = -QuarterArc;
      end
    end
    for (int i = 0; i < CordicSteps; i++) begin
      dx = shr(y, i);
      dy = shr(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += arc_q30(i);
      end else begin
        x -= dx; y += dy; z -= arc_q30(i);
      end
    end
    a = shr(z + 8192, 14);
    return (a < 0) ? a + 2 * HalfTurn : a;
  endfunction

  function automatic longint isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b; r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint limited(longint mag);
    longint unsigned p;
    p = (longint'(m_speed) * mag) >> 16;
    return (p < m_speed) ? p : m_speed;
  endfunction

  function automatic void predict_command(beat_t b);
    cmd_beat_t c;
    longint num, den, diff, mag, r, dx, dy, span;
    c = '{0, 0, 0, 0};
    if (b.action) begin
      m_tx = b.gx; m_ty = b.gy;
      m_head = heading(m_ty - m_ly, m_tx - m_lx);
      m_phase = PhRot;
      return;
    end
    m_lx = b.ox; m_ly = b.oy;
    if (m_phase == PhRot) begin
      num = 2 * (longint'(b.qw) * b.qz + longint'(b.qx) * b.qy);
      den = (longint'(1) << 28) - 2 * (longint'(b.qy) * b.qy + longint'(b.qz) * b.qz);
      diff = m_head - heading(num, den);
      mag = diff < 0 ? -diff : diff;
      if (mag < m_angtol) m_phase = PhDrive;
      else begin
        r = limited(mag);
        c.ang = 20'((diff > 0) ? r : -r);
      end
    end else if (m_phase == PhDrive) begin
      dx = m_tx - m_lx; dy = m_ty - m_ly;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      if (dx >= (longint'(1) << 31) || dy >= (longint'(1) << 31)) span = longint'(1) << 31;
      else span = isqrt(dx * dx + dy * dy);
      if (span < m_postol) begin
        c.reached = 1; m_phase = PhIdle;
      end else begin
        c.lin = 19'(limited(span));
      end
    end else begin
      return;
    end
    c.ph = m_phase;
    expected_cmds.push_back(c);
  endfunction

  function automatic beat_t rand_beat(bit act);
    beat_t b;
    b.action = act;
    b.gx = $urandom; b.gy = $urandom; b.ox = $urandom; b.oy = $urandom;
    b.qx = 16'($urandom_range(32768) - 16384); b.qy = 16'($urandom_range(32768) - 16384);
    b.qz = 16'($urandom_range(32768) - 16384); b.qw = 16'($urandom_range(32768) - 16384);
    return b;
  endfunction

  // A goal near the origin plus samples homing in: yaw walks toward the heading,
  // then position walks toward the goal.
  task automatic add_mission();
    beat_t b;
    int n;
    longint tx, ty, px, py;
    real h, y;
    tx = $signed($urandom_range(1 << 20)) - (1 << 19);
    ty = $signed($urandom_range(1 << 20)) - (1 << 19);
    b = rand_beat(1); b.gx = 32'(tx); b.gy = 32'(ty);
    pending.push_back(b);
    h = $atan2(real'(ty - m_ly), real'(tx - m_lx));
    n = $urandom_range(1, 5);
    for (int i = n; i >= 0; i--) begin
      b = rand_beat(0);
      b.ox = 32'(m_lx); b.oy = 32'(m_ly);
      y = h + (i * 0.4 + ($urandom_range(20) - 10) * 0.001) * (i % 2 ? 1 : -1);
      b.qx = 0; b.qy = 0;
      b.qz = 16'($rtoi(16384.0 * $sin(y / 2)));
      b.qw = 16'($rtoi(16384.0 * $cos(y / 2)));
      pending.push_back(b);
    end
    n = $urandom_range(1, 6);
    px = m_lx; py = m_ly;
    for (int i = n; i >= 0; i--) begin
      b = rand_beat(0);
      b.ox = 32'(tx - (tx - px) * i / (n + 1) + $signed($urandom_range(200)) - 100);
      b.oy = 32'(ty - (ty - py) * i / (n + 1) + $signed($urandom_range(200)) - 100);
      if (i == 0 && $urandom_range(1)) begin
        b.ox = 32'(tx); b.oy = 32'(ty);
      end
      pending.push_back(b);
    end
  endtask

  // Stage the queue into the model so the mission builder sees current position.
  task automatic flush_to_model();
    beat_t b;
    while (pending.size() > 0) begin
      b = pending.pop_front();
      staged.push_back(b);
      predict_command(b);
    end
  endtask

  task automatic wait_idle();
    while (staged.size() > 0 || expected_cmds.size() > 0 || in_valid) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [19:0] val);
    @(posedge clk);
    cfg_we <= 1; cfg_idx <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == RegMax) m_speed = val[18:0];
    else if (idx == RegAng) m_angtol = val[16:0];
    else m_postol = val;
  endtask

  int in_gap = 0;
  int out_gap = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        staged.pop_front();
        in_gap = $urandom_range(0, 6);
      end
      if (!(in_valid && !in_ready)) begin
        if (in_gap > 0) begin
          in_gap--; in_valid <= 0;
        end else if (staged.size() > 0) begin
          in_valid <= 1;
          action <= staged[0].action;
          goal_x <= staged[0].gx; goal_y <= staged[0].gy;
          odom_x <= staged[0].ox; odom_y <= staged[0].oy;
          quat_x <= staged[0].qx; quat_y <= staged[0].qy;
          quat_z <= staged[0].qz; quat_w <= staged[0].qw;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  always @(posedge clk) begin
    cmd_beat_t e;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_cmds.size() == 0) begin
          $display("%0t: unexpected result ang=%0d lin=%0d reached=%0d phase=%0d",
                   $time, angular_rate, linear_rate, goal_reached, phase_now);
          errors++;
        end else begin
          e = expected_cmds.pop_front();
          if (angular_rate !== e.ang || linear_rate !== e.lin ||
              goal_reached !== e.reached || phase_now !== e.ph) begin
            $display("%0t: expected ang=%0d lin=%0d reached=%0d phase=%0d", $time,
                     e.ang, e.lin, e.reached, e.ph);
            $display("%0t: actual   ang=%0d lin=%0d reached=%0d phase=%0d", $time,
                     angular_rate, linear_rate, goal_reached, phase_now);
            errors++;
          end
        end
        out_gap = $urandom_range(0, 6);
      end
      if (out_gap > 0) begin
        out_gap--; out_ready <= 0;
      end else begin
        out_ready <= 1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && !finished) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) watch <= 0;
      else watch <= watch + 1;
      if (watch >= WatchLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    beat_t b;
    m_speed = 32768; m_angtol = 655; m_postol = 6554;
    m_phase = PhIdle;
    m_lx = 0; m_ly = 0; m_tx = 0; m_ty = 0; m_head = 0;
    repeat (10) @(posedge clk);
    rst <= 0;

    // Directed part: idle odometry, goal at current point, zero quaternion,
    // extreme coordinates and saturated distance.
    b = rand_beat(0); b.ox = 0; b.oy = 0; pending.push_back(b);
    b = rand_beat(1); b.gx = 0; b.gy = 0; pending.push_back(b);
    b = rand_beat(0); b.ox = 0; b.oy = 0; b.qx = 0; b.qy = 0; b.qz = 0; b.qw = 0;
    pending.push_back(b);
    b = rand_beat(0); b.ox = 0; b.oy = 0; pending.push_back(b);
    b = rand_beat(1); b.gx = 32'sh7fffffff; b.gy = 32'sh80000000; pending.push_back(b);
    b = rand_beat(0); b.ox = 32'sh80000000; b.oy = 32'sh7fffffff;
    b.qx = 16384; b.qy = -16384; b.qz = 16384; b.qw = -16384; pending.push_back(b);
    b = rand_beat(0); b.qx = -16384; b.qy = 16384; b.qz = -16384; b.qw = 16384;
    pending.push_back(b);
    b = rand_beat(1); b.gx = 32'sh80000000; b.gy = 32'sh80000000; pending.push_back(b);
    for (int i = 0; i < 4; i++) pending.push_back(rand_beat(0));
    flush_to_model();
    add_mission(); flush_to_model();
    add_mission(); flush_to_model();

    // The sender pauses here until every result beat has come back.
    wait_idle();

    for (int phase_no = 0; phase_no < 7; phase_no++) begin
      wait_idle();
      case (phase_no)
        0: begin
          write_reg(RegMax, 20'd0); write_reg(RegAng, 20'd0); write_reg(RegPos, 20'd0);
        end
        1: begin
          write_reg(RegMax, 20'h7ffff); write_reg(RegAng, 20'h1ffff);
          write_reg(RegPos, 20'hfffff);
        end
        2: begin
          write_reg(RegMax, 20'd262144); write_reg(RegAng, 20'd65536);
          write_reg(RegPos, 20'd655360);
        end
        3: begin
          write_reg(RegMax, 20'hfffff); write_reg(RegAng, 20'd1); write_reg(RegPos, 20'd1);
        end
        default: begin
          write_reg(RegMax, 20'($urandom_range(262144)));
          write_reg(RegAng, 20'($urandom_range(3000)));
          write_reg(RegPos, 20'($urandom_range(20000)));
        end
      endcase
      for (int k = 0; k < 26; k++) begin
        if ($urandom_range(9) < 8) add_mission();
        else pending.push_back(rand_beat(1'($urandom_range(1))));
        flush_to_model();
      end
    end

    wait_idle();
    finished = 1;
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
